FILE: hw/rtl/sva_pkg.sv
// Shared types and constants for the sound voice allocator.
package sva_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int CH_IDX_W     = 5;
    localparam int CHANNEL_W    = 3;
    localparam int ID_W         = 15;
    localparam int AMP_W        = 8;
    localparam int PERS_W       = 15;
    localparam int PRIO_W       = 3;
    localparam int TICK_W       = 32;
    localparam int SND_W        = 16;
    localparam int AGE_W        = 32;
    localparam int MVOL_W       = 4;
    localparam int VOL_SHIFT    = 3;
    localparam int PROD_W       = AMP_W + MVOL_W;

    localparam logic [SND_W-1:0]  NO_SOUND      = '1;
    localparam logic [PRIO_W-1:0] PRIO_VERY_LOW = PRIO_W'(1);
    localparam logic [AGE_W-1:0]  AGE_MAX       = {1'b0, {(AGE_W-1){1'b1}}};
    localparam logic [MVOL_W-1:0] MVOL_RESET    = MVOL_W'(8);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AGE,
        ST_LAUNCH,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef enum logic {
        REG_SOUND_ENABLED = 1'b0,
        REG_MASTER_VOLUME = 1'b1
    } cfg_reg_t;

    // request fields broadcast to every cell during the scan
    typedef struct packed {
        logic              p1_en;
        logic [ID_W-1:0]   id;
        logic [AMP_W-1:0]  amp;
        logic [PRIO_W-1:0] prio;
    } req_t;

    typedef struct packed {
        logic              en;
        logic [TICK_W-1:0] elapsed;
    } age_upd_t;

    typedef struct packed {
        logic                en;
        logic [CH_IDX_W-1:0] idx;
        logic [ID_W-1:0]     id;
        logic [AMP_W-1:0]    amp;
        logic [PRIO_W-1:0]   prio;
        logic [AGE_W-1:0]    age;
    } stamp_t;

    // search token walking the chain: one found flag and index per pass
    typedef struct packed {
        logic                    valid;
        logic                    f1;
        logic [CH_IDX_W-1:0]     i1;
        logic                    f2;
        logic [CH_IDX_W-1:0]     i2;
        logic                    f3;
        logic [CH_IDX_W-1:0]     i3;
        logic                    f4;
        logic [CH_IDX_W-1:0]     i4;
        logic signed [AGE_W-1:0] best_age;
    } tok_t;

endpackage

FILE: hw/rtl/sva_cell.sv
// One voice channel: holds its state and folds its candidacy into the passing token.
module sva_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sva_pkg::CH_IDX_W-1:0]  cell_idx,
    input  sva_pkg::req_t                 req,
    input  sva_pkg::age_upd_t             age_upd,
    input  sva_pkg::stamp_t               stamp,
    input  sva_pkg::tok_t                 tok_in,
    output sva_pkg::tok_t                 tok_out
);
    import sva_pkg::*;

    logic [SND_W-1:0]         sound_reg;
    logic [AMP_W-1:0]         vol_reg;
    logic [PRIO_W-1:0]        prio_reg;
    logic signed [AGE_W-1:0]  age_reg;
    tok_t                     tok_reg;
    tok_t                     tok_next;

    logic [AGE_W+1:0]         age_sum;
    logic                     age_sat;
    logic [AGE_W-1:0]         age_added;
    logic                     hit1;
    logic                     hit2;
    logic                     hit3;
    logic                     hit4;

    // signed age plus unsigned elapsed, saturating at the positive limit
    always_comb
    begin
        age_sum   = {{2{age_reg[AGE_W-1]}}, age_reg} + {2'b00, age_upd.elapsed};
        age_sat   = !age_sum[AGE_W+1] && (age_sum[AGE_W:AGE_W-1] != 2'b00);
        age_added = age_sat ? AGE_MAX : age_sum[AGE_W-1:0];
    end

    always_comb
    begin
        hit1 = req.p1_en && (sound_reg == {1'b0, req.id}) && (vol_reg <= req.amp);
        hit2 = vol_reg < req.amp;
        hit3 = prio_reg < req.prio;
        hit4 = age_reg > tok_in.best_age;

        tok_next = tok_in;
        if (!tok_in.f1 && hit1)
        begin
            tok_next.f1 = 1'b1;
            tok_next.i1 = cell_idx;
        end
        if (!tok_in.f2 && hit2)
        begin
            tok_next.f2 = 1'b1;
            tok_next.i2 = cell_idx;
        end
        if (!tok_in.f3 && hit3)
        begin
            tok_next.f3 = 1'b1;
            tok_next.i3 = cell_idx;
        end
        // strict compare keeps the lowest index on a tie
        if (hit4)
        begin
            tok_next.f4       = 1'b1;
            tok_next.i4       = cell_idx;
            tok_next.best_age = age_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_reg <= NO_SOUND;
            vol_reg   <= '0;
            prio_reg  <= '0;
            age_reg   <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (stamp.en && (stamp.idx == cell_idx))
            begin
                sound_reg <= {1'b0, stamp.id};
                vol_reg   <= stamp.amp;
                prio_reg  <= stamp.prio;
                age_reg   <= stamp.age;
            end
            else if (age_upd.en)
            begin
                age_reg <= age_added;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: hw/rtl/sva_ctrl.sv
// Request sequencer: takes a beat, ages, scans unless refused, stamps a grant, reports.
module sva_ctrl #(
    parameter int CHANNELS = sva_pkg::CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [sva_pkg::ID_W-1:0]       sound_id,
    input  logic [sva_pkg::AMP_W-1:0]      amplitude,
    input  logic [sva_pkg::PERS_W-1:0]     persistence,
    input  logic [sva_pkg::PRIO_W-1:0]     priority_req,
    input  logic [sva_pkg::TICK_W-1:0]     now_tick,
    input  logic                           sound_loaded,
    input  logic                           sound_enabled,
    input  logic [sva_pkg::MVOL_W-1:0]     master_volume,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           granted,
    output logic [sva_pkg::CHANNEL_W-1:0]  channel,
    output logic [sva_pkg::AMP_W-1:0]      channel_volume,
    output sva_pkg::req_t                  req,
    output sva_pkg::age_upd_t              age_upd,
    output sva_pkg::stamp_t                stamp,
    output sva_pkg::tok_t                  head_tok,
    input  sva_pkg::tok_t                  tail_tok
);
    import sva_pkg::*;

    state_t                state_reg;
    state_t                state_next;
    logic [ID_W-1:0]       id_reg;
    logic [AMP_W-1:0]      amp_reg;
    logic [PERS_W-1:0]     pers_reg;
    logic [PRIO_W-1:0]     prio_reg;
    logic [TICK_W-1:0]     now_reg;
    logic                  loaded_reg;
    logic [TICK_W-1:0]     last_tick_reg;
    logic [TICK_W-1:0]     last_tick_next;
    logic                  grant_reg;
    logic                  grant_next;
    logic [CH_IDX_W-1:0]   pick_reg;
    logic [CH_IDX_W-1:0]   pick_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  granted_reg;
    logic [CHANNEL_W-1:0]  channel_reg;
    logic [AMP_W-1:0]      chvol_reg;

    logic                  accept;
    logic                  reject;
    logic                  out_free;
    logic                  out_load;
    logic                  found;
    logic [CH_IDX_W-1:0]   found_idx;
    logic [PROD_W-1:0]     prod;
    logic [PROD_W-1:0]     scaled;
    logic [AMP_W-1:0]      vol_sat;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign reject   = !sound_enabled || (master_volume == '0) || (amplitude == '0);
    assign out_free = !out_valid_reg || !out_stall;

    // pass priority: same id, quieter channel, lower priority, oldest
    always_comb
    begin
        found     = 1'b1;
        found_idx = tail_tok.i4;
        if (tail_tok.f1)
            found_idx = tail_tok.i1;
        else if (tail_tok.f2)
            found_idx = tail_tok.i2;
        else if (tail_tok.f3)
            found_idx = tail_tok.i3;
        else if (!tail_tok.f4)
            found = 1'b0;
    end

    always_comb
    begin
        prod    = PROD_W'(amp_reg) * PROD_W'(master_volume);
        scaled  = prod >> VOL_SHIFT;
        vol_sat = (scaled > PROD_W'({AMP_W{1'b1}})) ? '1 : scaled[AMP_W-1:0];
    end

    assign req.p1_en = prio_reg > PRIO_VERY_LOW;
    assign req.id    = id_reg;
    assign req.amp   = amp_reg;
    assign req.prio  = prio_reg;

    always_comb
    begin
        state_next     = state_reg;
        last_tick_next = last_tick_reg;
        grant_next     = grant_reg;
        pick_next      = pick_reg;
        out_load       = 1'b0;
        age_upd.en     = 1'b0;
        age_upd.elapsed = now_reg - last_tick_reg;
        head_tok       = '0;
        stamp.en       = 1'b0;
        stamp.idx      = pick_reg;
        stamp.id       = id_reg;
        stamp.amp      = amp_reg;
        stamp.prio     = prio_reg;
        stamp.age      = AGE_W'(0) - AGE_W'(pers_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    grant_next = 1'b0;
                    state_next = reject ? ST_DONE : ST_AGE;
                end
            end
            ST_AGE:
            begin
                age_upd.en     = 1'b1;
                last_tick_next = now_reg;
                state_next     = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                head_tok.valid = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (tail_tok.valid)
                begin
                    grant_next = found && loaded_reg;
                    pick_next  = found_idx;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    stamp.en   = grant_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_tick_reg <= '0;
            grant_reg     <= 1'b0;
            pick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_tick_reg <= last_tick_next;
            grant_reg     <= grant_next;
            pick_reg      <= pick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg     <= sound_id;
            amp_reg    <= amplitude;
            pers_reg   <= persistence;
            prio_reg   <= priority_req;
            now_reg    <= now_tick;
            loaded_reg <= sound_loaded;
        end
        if (out_load)
        begin
            granted_reg <= grant_reg;
            channel_reg <= grant_reg ? pick_reg[CHANNEL_W-1:0] : '0;
            chvol_reg   <= grant_reg ? vol_sat : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign granted        = granted_reg;
    assign channel        = channel_reg;
    assign channel_volume = chvol_reg;

`ifndef ASSERT_OFF
    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail_tok.valid |-> state_reg == ST_SCAN)
        else $error("scan token left the chain outside the scan");

    a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && grant_reg) |-> (int'(pick_reg) < CHANNELS))
        else $error("granted channel beyond the pool");

    a_reject_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && reject) |=> state_reg == ST_DONE)
        else $error("rejected request went through the scan");

    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !granted) |-> (channel == '0 && channel_volume == '0))
        else $error("refused beat carries a channel or volume");
`endif

endmodule

FILE: hw/rtl/sound_voice_allocator.sv
// Top level: configuration registers, the sequencer and the chain of channel cells.
//
// Each request goes through these steps from its input beat to its result:
// the elapsed ticks are added to every channel age, the search token is
// launched, the token walks the chain of channel cells (one cell per
// cycle), and the sequencer picks the channel, stamps it if granted and
// loads the output register. A request refused by the enable, master
// volume or zero amplitude skips the aging and the scan. One request is
// in work at a time; the next may be taken while a finished result still
// waits in the output register. Configuration writes are always ready.
module sound_voice_allocator #(
    parameter int CHANNELS = sva_pkg::CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [sva_pkg::ID_W-1:0]       sound_id,
    input  logic [sva_pkg::AMP_W-1:0]      amplitude,
    input  logic [sva_pkg::PERS_W-1:0]     persistence,
    input  logic [sva_pkg::PRIO_W-1:0]     priority_req,
    input  logic [sva_pkg::TICK_W-1:0]     now_tick,
    input  logic                           sound_loaded,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           granted,
    output logic [sva_pkg::CHANNEL_W-1:0]  channel,
    output logic [sva_pkg::AMP_W-1:0]      channel_volume,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [sva_pkg::MVOL_W-1:0]     cfg_data
);
    import sva_pkg::*;

    logic               enabled_reg;
    logic [MVOL_W-1:0]  mvol_reg;
    req_t               req;
    age_upd_t           age_upd;
    stamp_t             stamp;
    tok_t               chain [CHANNELS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
            mvol_reg    <= MVOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SOUND_ENABLED: enabled_reg <= cfg_data[0];
                REG_MASTER_VOLUME: mvol_reg    <= cfg_data;
                default:           mvol_reg    <= mvol_reg;
            endcase
        end
    end

    sva_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sound_id       (sound_id),
        .amplitude      (amplitude),
        .persistence    (persistence),
        .priority_req   (priority_req),
        .now_tick       (now_tick),
        .sound_loaded   (sound_loaded),
        .sound_enabled  (enabled_reg),
        .master_volume  (mvol_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .granted        (granted),
        .channel        (channel),
        .channel_volume (channel_volume),
        .req            (req),
        .age_upd        (age_upd),
        .stamp          (stamp),
        .head_tok       (chain[0]),
        .tail_tok       (chain[CHANNELS])
    );

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_cell
        sva_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (CH_IDX_W'(i)),
            .req      (req),
            .age_upd  (age_upd),
            .stamp    (stamp),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

endmodule
